// ===== rtl/gdpq_pkg.sv =====
// ----------------------------------------------------------------------------
// gdpq_pkg: shared definitions of the goal-distance priority queue
// Field widths, action and status codes, controller commands and status.
// ----------------------------------------------------------------------------
package gdpq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 32;
   localparam int ID_BITS_DEFAULT     = 8;

   localparam int ACTION_W = 3;
   localparam int NODE_W   = 8;
   localparam int COORD_W  = 16;
   localparam int PLEN_W   = 24;
   localparam int SLOT_W   = 5;
   localparam int STATUS_W = 3;
   localparam int KEY_W    = 32;
   localparam int COUNT_W  = 6;
   localparam int WEIGHT_W = 12;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_X      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_Y      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATH_WEIGHT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_WEIGHT = 2'd3;

   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 12'd256;

   localparam logic [ACTION_W-1:0] ACT_INSERT     = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_REMOVE_ID  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_REMOVE_IDX = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_POP        = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_PEEK       = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_READ       = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_FIND       = 3'd6;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

   localparam logic [KEY_W-1:0]  KEY_INF        = 32'hFFFF_FFFF;
   localparam logic [KEY_W-1:0]  KEY_MAX_FINITE = 32'hFFFF_FFFE;
   localparam logic [PLEN_W-1:0] PATH_INF       = 24'hFF_FFFF;

   localparam int OP_W = 5;
   localparam logic [OP_W-1:0] C_NOP        = 5'd0;
   localparam logic [OP_W-1:0] C_LOAD       = 5'd1;
   localparam logic [OP_W-1:0] C_SQ1        = 5'd2;
   localparam logic [OP_W-1:0] C_SQ2        = 5'd3;
   localparam logic [OP_W-1:0] C_SQRT       = 5'd4;
   localparam logic [OP_W-1:0] C_MUL1       = 5'd5;
   localparam logic [OP_W-1:0] C_MUL2       = 5'd6;
   localparam logic [OP_W-1:0] C_CNT_ZERO   = 5'd7;
   localparam logic [OP_W-1:0] C_CNT_SLOT   = 5'd8;
   localparam logic [OP_W-1:0] C_CNT_LAST   = 5'd9;
   localparam logic [OP_W-1:0] C_RD         = 5'd10;
   localparam logic [OP_W-1:0] C_RD_NEXT    = 5'd11;
   localparam logic [OP_W-1:0] C_RD_PREV    = 5'd12;
   localparam logic [OP_W-1:0] C_INC        = 5'd13;
   localparam logic [OP_W-1:0] C_SHIFT_DN   = 5'd14;
   localparam logic [OP_W-1:0] C_SHIFT_UP   = 5'd15;
   localparam logic [OP_W-1:0] C_WR_NEW     = 5'd16;
   localparam logic [OP_W-1:0] C_FILL_DEC   = 5'd17;
   localparam logic [OP_W-1:0] C_POS        = 5'd18;
   localparam logic [OP_W-1:0] C_HOLD_ENTRY = 5'd19;
   localparam logic [OP_W-1:0] C_SET_ERR    = 5'd20;
   localparam logic [OP_W-1:0] C_SET_INS    = 5'd21;
   localparam logic [OP_W-1:0] C_SET_FULL   = 5'd22;
   localparam logic [OP_W-1:0] C_RESP       = 5'd23;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [STATUS_W-1:0] status;
      logic                req_ready;
   } gdpq_cmd_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                req_valid;
      logic                rsp_free;
      logic                sqrt_last;
      logic                cnt_ge_fill;
      logic                next_ge_fill;
      logic                cnt_eq_pos;
      logic                id_match;
      logic                key_gt;
      logic                fill_zero;
      logic                fill_full;
      logic                slot_bad;
   } gdpq_stat_type;

endpackage

// ===== rtl/gdpq_if.sv =====
// ----------------------------------------------------------------------------
// gdpq_req_if / gdpq_rsp_if: request and response channels
// Valid/ready channels carrying one request word or one response word.
// ----------------------------------------------------------------------------
interface gdpq_req_if
   import gdpq_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic [ACTION_W-1:0]        action;
   logic [NODE_W-1:0]          node_id;
   logic signed [COORD_W-1:0]  node_x;
   logic signed [COORD_W-1:0]  node_y;
   logic [PLEN_W-1:0]          path_length;
   logic [SLOT_W-1:0]          slot;

   modport source (output valid, action, node_id, node_x, node_y, path_length, slot,
                   input ready);
   modport sink   (input valid, action, node_id, node_x, node_y, path_length, slot,
                   output ready);
endinterface

interface gdpq_rsp_if
   import gdpq_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [NODE_W-1:0]   found_id;
   logic [KEY_W-1:0]    found_key;
   logic [SLOT_W-1:0]   found_slot;
   logic [COUNT_W-1:0]  entry_count;

   modport source (output valid, status, found_id, found_key, found_slot, entry_count,
                   input ready);
   modport sink   (input valid, status, found_id, found_key, found_slot, entry_count,
                   output ready);
endinterface

// ===== rtl/gdpq_ram.sv =====
// ----------------------------------------------------------------------------
// gdpq_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gdpq_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== rtl/gdpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// gdpq_ctrl: operation sequencer
// Steps key calculation, scans, shifts and response hand-off one command a cycle.
// ----------------------------------------------------------------------------
module gdpq_ctrl
   import gdpq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  gdpq_stat_type stat,
   output gdpq_cmd_type  cmd
);
   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_DEC      = 5'd1;
   localparam logic [4:0] S_SQ2      = 5'd2;
   localparam logic [4:0] S_SQRT     = 5'd3;
   localparam logic [4:0] S_MUL1     = 5'd4;
   localparam logic [4:0] S_MUL2     = 5'd5;
   localparam logic [4:0] S_FIND_RD  = 5'd6;
   localparam logic [4:0] S_FIND_CHK = 5'd7;
   localparam logic [4:0] S_REM_RD   = 5'd8;
   localparam logic [4:0] S_REM_WR   = 5'd9;
   localparam logic [4:0] S_POS_RD   = 5'd10;
   localparam logic [4:0] S_POS_CHK  = 5'd11;
   localparam logic [4:0] S_UP_RD    = 5'd12;
   localparam logic [4:0] S_UP_WR    = 5'd13;
   localparam logic [4:0] S_GET_RD   = 5'd14;
   localparam logic [4:0] S_GET_CHK  = 5'd15;
   localparam logic [4:0] S_RESP     = 5'd16;

   logic [4:0] state_ff;
   logic [4:0] state_in;

   always_comb begin
      state_in       = state_ff;
      cmd.op         = C_NOP;
      cmd.status     = ST_OK;
      cmd.req_ready  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.req_ready = 1'b1;
            if (stat.req_valid) begin
               cmd.op   = C_LOAD;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            unique case (stat.action) inside
               ACT_INSERT: begin
                  cmd.op   = C_SQ1;
                  state_in = S_SQ2;
               end
               ACT_REMOVE_ID, ACT_FIND: begin
                  cmd.op   = C_CNT_ZERO;
                  state_in = S_FIND_RD;
               end
               ACT_REMOVE_IDX, ACT_READ: begin
                  if (stat.slot_bad) begin
                     cmd.op     = C_SET_ERR;
                     cmd.status = ST_EMPTY;
                     state_in   = S_RESP;
                  end else begin
                     cmd.op   = C_CNT_SLOT;
                     state_in = S_GET_RD;
                  end
               end
               ACT_POP, ACT_PEEK: begin
                  if (stat.fill_zero) begin
                     cmd.op     = C_SET_ERR;
                     cmd.status = ST_EMPTY;
                     state_in   = S_RESP;
                  end else begin
                     cmd.op   = C_CNT_LAST;
                     state_in = S_GET_RD;
                  end
               end
               default: begin
                  cmd.op     = C_SET_ERR;
                  cmd.status = ST_EMPTY;
                  state_in   = S_RESP;
               end
            endcase
         end
         S_SQ2: begin
            cmd.op   = C_SQ2;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.op = C_SQRT;
            if (stat.sqrt_last) begin
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            cmd.op   = C_MUL1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.op   = C_MUL2;
            state_in = S_FIND_RD;
         end
         S_FIND_RD: begin
            if (stat.cnt_ge_fill) begin
               if (stat.action == ACT_INSERT) begin
                  if (stat.fill_full) begin
                     cmd.op     = C_SET_FULL;
                     cmd.status = ST_FULL;
                     state_in   = S_RESP;
                  end else begin
                     cmd.op   = C_CNT_ZERO;
                     state_in = S_POS_RD;
                  end
               end else begin
                  cmd.op     = C_SET_ERR;
                  cmd.status = ST_NOT_FOUND;
                  state_in   = S_RESP;
               end
            end else begin
               cmd.op   = C_RD;
               state_in = S_FIND_CHK;
            end
         end
         S_FIND_CHK: begin
            if (!stat.id_match) begin
               cmd.op   = C_INC;
               state_in = S_FIND_RD;
            end else if (stat.action == ACT_INSERT) begin
               if (stat.key_gt) begin
                  cmd.op     = C_SET_INS;
                  cmd.status = ST_REJECTED;
                  state_in   = S_RESP;
               end else begin
                  state_in = S_REM_RD;
               end
            end else begin
               cmd.op   = C_HOLD_ENTRY;
               state_in = (stat.action == ACT_FIND) ? S_RESP : S_REM_RD;
            end
         end
         S_REM_RD: begin
            if (stat.next_ge_fill) begin
               cmd.op   = C_FILL_DEC;
               state_in = (stat.action == ACT_INSERT) ? S_POS_RD : S_RESP;
            end else begin
               cmd.op   = C_RD_NEXT;
               state_in = S_REM_WR;
            end
         end
         S_REM_WR: begin
            cmd.op   = C_SHIFT_DN;
            state_in = S_REM_RD;
         end
         S_POS_RD: begin
            if (stat.cnt_ge_fill) begin
               cmd.op   = C_POS;
               state_in = S_UP_RD;
            end else begin
               cmd.op   = C_RD;
               state_in = S_POS_CHK;
            end
         end
         S_POS_CHK: begin
            if (stat.key_gt) begin
               cmd.op   = C_POS;
               state_in = S_UP_RD;
            end else begin
               cmd.op   = C_INC;
               state_in = S_POS_RD;
            end
         end
         S_UP_RD: begin
            if (stat.cnt_eq_pos) begin
               cmd.op   = C_WR_NEW;
               state_in = S_RESP;
            end else begin
               cmd.op   = C_RD_PREV;
               state_in = S_UP_WR;
            end
         end
         S_UP_WR: begin
            cmd.op   = C_SHIFT_UP;
            state_in = S_UP_RD;
         end
         S_GET_RD: begin
            cmd.op   = C_RD;
            state_in = S_GET_CHK;
         end
         S_GET_CHK: begin
            cmd.op = C_HOLD_ENTRY;
            if (stat.action == ACT_REMOVE_IDX || stat.action == ACT_POP) begin
               state_in = S_REM_RD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (stat.rsp_free) begin
               cmd.op   = C_RESP;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ===== rtl/gdpq_dp.sv =====
// ----------------------------------------------------------------------------
// gdpq_dp: queue datapath
// Key arithmetic with serial square root, entry RAM, counters, response word.
// ----------------------------------------------------------------------------
module gdpq_dp
   import gdpq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
   parameter int ID_BITS     = ID_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  gdpq_cmd_type         cmd,
   output gdpq_stat_type        stat,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   gdpq_req_if.sink             req,
   gdpq_rsp_if.source           rsp
);
   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int FW = $clog2(QUEUE_DEPTH + 1);
   localparam int IW = (ID_BITS < NODE_W) ? ID_BITS : NODE_W;
   localparam int CW = (FW > COUNT_W) ? FW : COUNT_W;
   localparam int RW = IW + KEY_W;

   logic signed [COORD_W-1:0]  gx_ff, gy_ff;
   logic [WEIGHT_W-1:0]        pw_ff, gw_ff;

   logic [ACTION_W-1:0] act_ff;
   logic [IW-1:0]       id_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [PLEN_W-1:0]   plen_ff;
   logic [15:0]         ax_ff, ay_ff;
   logic [32:0]         sq_ff, rem_ff, res_ff, bit_ff;
   logic [35:0]         p1_ff;
   logic [KEY_W-1:0]    key_ff;

   logic [FW-1:0] cnt_ff, pos_ff, fill_ff;

   logic [STATUS_W-1:0] res_st_ff;
   logic [IW-1:0]       res_id_ff;
   logic [KEY_W-1:0]    res_key_ff;
   logic [CW-1:0]       res_slot_ff;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_st_ff;
   logic [NODE_W-1:0]   rsp_id_ff;
   logic [KEY_W-1:0]    rsp_key_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [COUNT_W-1:0]  rsp_cnt_ff;

   logic signed [16:0] dx, dy;
   logic [16:0]        adx, ady;
   logic [31:0]        ax_sq, ay_sq;
   logic [28:0]        gw_prod;
   logic [33:0]        sq_try;
   logic [36:0]        sum;
   logic [36:0]        sum_sh;
   logic [KEY_W-1:0]   key_calc;
   logic [FW:0]        cnt_next;
   logic [FW-1:0]      cnt_prev;
   logic [CW-1:0]      slot_ext, cnt_ext, fill_ext;

   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [RW-1:0] ram_wdata, ram_rdata;
   logic [IW-1:0] rd_id;
   logic [KEY_W-1:0] rd_key;

   assign dx  = 17'(req.node_x) - 17'(gx_ff);
   assign dy  = 17'(req.node_y) - 17'(gy_ff);
   assign adx = dx[16] ? -dx : dx;
   assign ady = dy[16] ? -dy : dy;

   assign ax_sq    = ax_ff * ax_ff;
   assign ay_sq    = ay_ff * ay_ff;
   assign gw_prod  = gw_ff * res_ff[16:0];
   assign sq_try   = 34'(res_ff) + 34'(bit_ff);
   assign sum      = 37'(p1_ff) + 37'(gw_prod);
   assign sum_sh   = sum >> 8;
   assign key_calc = (plen_ff == PATH_INF) ? KEY_INF :
                     (sum_sh > 37'(KEY_MAX_FINITE)) ? KEY_MAX_FINITE : sum_sh[KEY_W-1:0];

   assign cnt_next = (FW + 1)'(cnt_ff) + 1'b1;
   assign cnt_prev = cnt_ff - 1'b1;
   assign slot_ext = CW'(slot_ff);
   assign cnt_ext  = CW'(cnt_ff);
   assign fill_ext = CW'(fill_ff);

   assign rd_id  = ram_rdata[RW-1:KEY_W];
   assign rd_key = ram_rdata[KEY_W-1:0];

   always_comb begin
      ram_re    = 1'b0;
      ram_raddr = cnt_ff[AW-1:0];
      ram_we    = 1'b0;
      ram_waddr = cnt_ff[AW-1:0];
      ram_wdata = ram_rdata;
      case (cmd.op) inside
         C_RD: begin
            ram_re = 1'b1;
         end
         C_RD_NEXT: begin
            ram_re    = 1'b1;
            ram_raddr = cnt_next[AW-1:0];
         end
         C_RD_PREV: begin
            ram_re    = 1'b1;
            ram_raddr = cnt_prev[AW-1:0];
         end
         C_SHIFT_DN, C_SHIFT_UP: begin
            ram_we = 1'b1;
         end
         C_WR_NEW: begin
            ram_we    = 1'b1;
            ram_wdata = {id_ff, key_ff};
         end
         default: begin
            ram_re = 1'b0;
         end
      endcase
   end

   gdpq_ram #(
      .WIDTH(RW),
      .DEPTH(QUEUE_DEPTH)
   ) u_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re   (ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         gx_ff <= '0;
         gy_ff <= '0;
         pw_ff <= WEIGHT_RESET;
         gw_ff <= WEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GOAL_X:      gx_ff <= csr_wdata;
            CSR_GOAL_Y:      gy_ff <= csr_wdata;
            CSR_PATH_WEIGHT: pw_ff <= csr_wdata[WEIGHT_W-1:0];
            CSR_GOAL_WEIGHT: gw_ff <= csr_wdata[WEIGHT_W-1:0];
            default:         gx_ff <= gx_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == C_RESP) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (cmd.op)
            C_LOAD: begin
               act_ff  <= req.action;
               id_ff   <= req.node_id[IW-1:0];
               slot_ff <= req.slot;
               plen_ff <= req.path_length;
               ax_ff   <= adx[15:0];
               ay_ff   <= ady[15:0];
            end
            C_SQ1: sq_ff <= 33'(ax_sq);
            C_SQ2: begin
               rem_ff <= sq_ff + 33'(ay_sq);
               res_ff <= '0;
               bit_ff <= 33'(1) << 32;
            end
            C_SQRT: begin
               if (34'(rem_ff) >= sq_try) begin
                  rem_ff <= rem_ff - sq_try[32:0];
                  res_ff <= (res_ff >> 1) + bit_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
            end
            C_MUL1: p1_ff <= pw_ff * plen_ff;
            C_MUL2: begin
               key_ff <= key_calc;
               cnt_ff <= '0;
            end
            C_CNT_ZERO: cnt_ff <= '0;
            C_CNT_SLOT: cnt_ff <= slot_ext[FW-1:0];
            C_CNT_LAST: cnt_ff <= fill_ff - 1'b1;
            C_INC:      cnt_ff <= cnt_next[FW-1:0];
            C_SHIFT_DN: cnt_ff <= cnt_next[FW-1:0];
            C_SHIFT_UP: cnt_ff <= cnt_prev;
            C_FILL_DEC: begin
               fill_ff <= fill_ff - 1'b1;
               cnt_ff  <= '0;
            end
            C_POS: begin
               pos_ff <= cnt_ff;
               cnt_ff <= fill_ff;
            end
            C_WR_NEW: begin
               fill_ff     <= fill_ff + 1'b1;
               res_st_ff   <= ST_OK;
               res_id_ff   <= id_ff;
               res_key_ff  <= key_ff;
               res_slot_ff <= cnt_ext;
            end
            C_HOLD_ENTRY: begin
               res_st_ff   <= ST_OK;
               res_id_ff   <= rd_id;
               res_key_ff  <= rd_key;
               res_slot_ff <= cnt_ext;
            end
            C_SET_ERR: begin
               res_st_ff   <= cmd.status;
               res_id_ff   <= '0;
               res_key_ff  <= '0;
               res_slot_ff <= '0;
            end
            C_SET_INS: begin
               res_st_ff   <= cmd.status;
               res_id_ff   <= id_ff;
               res_key_ff  <= key_ff;
               res_slot_ff <= cnt_ext;
            end
            C_SET_FULL: begin
               res_st_ff   <= cmd.status;
               res_id_ff   <= id_ff;
               res_key_ff  <= key_ff;
               res_slot_ff <= '0;
            end
            C_RESP: begin
               rsp_st_ff    <= res_st_ff;
               rsp_id_ff    <= NODE_W'(res_id_ff);
               rsp_key_ff   <= res_key_ff;
               rsp_slot_ff  <= res_slot_ff[SLOT_W-1:0];
               rsp_cnt_ff   <= fill_ext[COUNT_W-1:0];
            end
            default: begin
               cnt_ff <= cnt_ff;
            end
         endcase
      end
   end

   assign req.ready       = cmd.req_ready;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_st_ff;
   assign rsp.found_id    = rsp_id_ff;
   assign rsp.found_key   = rsp_key_ff;
   assign rsp.found_slot  = rsp_slot_ff;
   assign rsp.entry_count = rsp_cnt_ff;

   assign stat.action       = act_ff;
   assign stat.req_valid    = req.valid;
   assign stat.rsp_free     = !rsp_valid_ff || rsp.ready;
   assign stat.sqrt_last    = bit_ff[0];
   assign stat.cnt_ge_fill  = cnt_ff >= fill_ff;
   assign stat.next_ge_fill = cnt_next >= (FW + 1)'(fill_ff);
   assign stat.cnt_eq_pos   = cnt_ff == pos_ff;
   assign stat.id_match     = rd_id == id_ff;
   assign stat.key_gt       = key_ff > rd_key;
   assign stat.fill_zero    = fill_ff == '0;
   assign stat.fill_full    = fill_ff >= FW'(QUEUE_DEPTH);
   assign stat.slot_bad     = slot_ext >= fill_ext;
endmodule

// ===== rtl/goal_distance_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// goal_distance_priority_queue_unit: sorted open list with goal-distance keys
// Insert: 17-step square root, then node scan, position scan and shift.
// One operation at a time: the next word is taken in the cycle after the
// response word is registered, later while one still waits.
// Reset: synchronous; empties the queue and restores the default weights.
// ----------------------------------------------------------------------------
module goal_distance_priority_queue_unit
   import gdpq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
   parameter int ID_BITS     = ID_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   gdpq_req_if.sink             req_ch,
   gdpq_rsp_if.source           rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);
   gdpq_cmd_type  cmd;
   gdpq_stat_type stat;

   gdpq_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .stat (stat),
      .cmd  (cmd)
   );

   gdpq_dp #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .ID_BITS    (ID_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req      (req_ch),
      .rsp      (rsp_ch)
   );
endmodule

// ===== rtl/gdpq_checker.sv =====
// ----------------------------------------------------------------------------
// gdpq_checker: port-level checks of the queue unit
// Valid/key hold, count bound, status range, empty/not-found fields cleared.
// ----------------------------------------------------------------------------
module gdpq_checker
   import gdpq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [NODE_W-1:0]   rsp_found_id,
   input logic [KEY_W-1:0]    rsp_found_key,
   input logic [SLOT_W-1:0]   rsp_found_slot,
   input logic [COUNT_W-1:0]  rsp_entry_count
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found_key))
      else $error("response word dropped or changed while stalled");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_entry_count) <= 32'(QUEUE_DEPTH) || QUEUE_DEPTH > 63)
      else $error("entry count beyond depth");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_FULL)
      else $error("bad status code");

   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_NOT_FOUND || rsp_status == ST_EMPTY) |->
      rsp_found_id == '0 && rsp_found_key == '0 && rsp_found_slot == '0)
      else $error("error response with nonzero fields");
endmodule

bind goal_distance_priority_queue_unit gdpq_checker #(
   .QUEUE_DEPTH(QUEUE_DEPTH)
) u_gdpq_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_status     (rsp_ch.status),
   .rsp_found_id   (rsp_ch.found_id),
   .rsp_found_key  (rsp_ch.found_key),
   .rsp_found_slot (rsp_ch.found_slot),
   .rsp_entry_count(rsp_ch.entry_count)
);

// ===== bench/goal_distance_priority_queue_unit_tb.sv =====
// ----------------------------------------------------------------------------
// goal_distance_priority_queue_unit_tb: self-checking bench of the open list
// Drives queue operations under random idling, tracks the sorted entries in
// a local copy, and compares every response word with the predicted one.
// ----------------------------------------------------------------------------
module goal_distance_priority_queue_unit_tb;
   import gdpq_pkg::*;

   localparam int DEPTH = QUEUE_DEPTH_DEFAULT;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;

   typedef struct packed {
      logic [ACTION_W-1:0]       action;
      logic [NODE_W-1:0]         node_id;
      logic signed [COORD_W-1:0] node_x;
      logic signed [COORD_W-1:0] node_y;
      logic [PLEN_W-1:0]         path_length;
      logic [SLOT_W-1:0]         slot;
   } op_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [NODE_W-1:0]   found_id;
      logic [KEY_W-1:0]    found_key;
      logic [SLOT_W-1:0]   found_slot;
      logic [COUNT_W-1:0]  entry_count;
   } answer_type;

   typedef struct packed {
      op_word_type op;
      logic        has_answer;
      answer_type  answer;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   gdpq_req_if req_ch ();
   gdpq_rsp_if rsp_ch ();

   goal_distance_priority_queue_unit dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // local copy of block state
   logic signed [COORD_W-1:0] m_goal_x, m_goal_y;
   logic [WEIGHT_W-1:0]       m_path_w, m_goal_w;
   logic [NODE_W-1:0]         m_ids [DEPTH];
   logic [KEY_W-1:0]          m_keys [DEPTH];
   int                        m_fill;

   answer_type answer_queue[$];
   answer_type typed_answers[$];
   logic       typed_valid[$];
   int         mismatches = 0;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   int         hold_off_cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] res, bit_val, rem;
      res = 0;
      rem = v;
      bit_val = 64'd1 << 62;
      while (bit_val > rem) bit_val = bit_val >> 2;
      while (bit_val != 0) begin
         if (rem >= res + bit_val) begin
            rem = rem - (res + bit_val);
            res = (res >> 1) + bit_val;
         end else begin
            res = res >> 1;
         end
         bit_val = bit_val >> 2;
      end
      return res;
   endfunction

   function automatic logic [KEY_W-1:0] goal_key(input op_word_type op);
      longint dx, dy;
      logic [63:0] sq, dist_val, sum;
      if (op.path_length == PATH_INF) return KEY_INF;
      dx = longint'(op.node_x) - longint'(m_goal_x);
      dy = longint'(op.node_y) - longint'(m_goal_y);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      sq = 64'(dx * dx) + 64'(dy * dy);
      dist_val = int_sqrt(sq);
      sum = (64'(m_path_w) * 64'(op.path_length) + 64'(m_goal_w) * dist_val) >> 8;
      if (sum > 64'(KEY_MAX_FINITE)) sum = 64'(KEY_MAX_FINITE);
      return sum[KEY_W-1:0];
   endfunction

   function automatic int locate_node(input logic [NODE_W-1:0] id);
      for (int i = 0; i < m_fill; i++) if (m_ids[i] == id) return i;
      return -1;
   endfunction

   function automatic void drop_entry(input int idx);
      for (int i = idx; i + 1 < m_fill; i++) begin
         m_ids[i] = m_ids[i + 1];
         m_keys[i] = m_keys[i + 1];
      end
      if (m_fill > 0) m_fill--;
   endfunction

   function automatic answer_type queue_step(input op_word_type op);
      answer_type a;
      int idx, pos;
      logic [KEY_W-1:0] key;
      a = '0;
      case (op.action) inside
         ACT_INSERT: begin
            key = goal_key(op);
            a.found_id = op.node_id;
            a.found_key = key;
            idx = locate_node(op.node_id);
            if (idx >= 0 && key > m_keys[idx]) begin
               a.status = ST_REJECTED;
               a.found_slot = idx[SLOT_W-1:0];
            end else begin
               if (idx >= 0) drop_entry(idx);
               if (m_fill >= DEPTH) begin
                  a.status = ST_FULL;
               end else begin
                  pos = m_fill;
                  for (int i = 0; i < m_fill; i++)
                     if (key > m_keys[i]) begin pos = i; break; end
                  for (int i = m_fill; i > pos; i--) begin
                     m_ids[i] = m_ids[i - 1];
                     m_keys[i] = m_keys[i - 1];
                  end
                  m_ids[pos] = op.node_id;
                  m_keys[pos] = key;
                  m_fill++;
                  a.found_slot = pos[SLOT_W-1:0];
               end
            end
         end
         ACT_REMOVE_ID, ACT_FIND: begin
            idx = locate_node(op.node_id);
            if (idx < 0) a.status = ST_NOT_FOUND;
            else begin
               a.found_id = m_ids[idx];
               a.found_key = m_keys[idx];
               a.found_slot = idx[SLOT_W-1:0];
               if (op.action == ACT_REMOVE_ID) drop_entry(idx);
            end
         end
         ACT_REMOVE_IDX, ACT_READ: begin
            if (int'(op.slot) >= m_fill) a.status = ST_EMPTY;
            else begin
               a.found_id = m_ids[op.slot];
               a.found_key = m_keys[op.slot];
               a.found_slot = op.slot;
               if (op.action == ACT_REMOVE_IDX) drop_entry(int'(op.slot));
            end
         end
         ACT_POP, ACT_PEEK: begin
            if (m_fill == 0) a.status = ST_EMPTY;
            else begin
               a.found_slot = SLOT_W'(m_fill - 1);
               a.found_id = m_ids[m_fill - 1];
               a.found_key = m_keys[m_fill - 1];
               if (op.action == ACT_POP) m_fill--;
            end
         end
         default: a.status = ST_EMPTY;
      endcase
      a.entry_count = COUNT_W'(m_fill);
      return a;
   endfunction

   // receiver: stall at random, hold off for a long stretch on request
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // check response words
   always @(posedge clock) begin
      answer_type got, want;
      logic typed;
      answer_type typed_ans;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.status, rsp_ch.found_id, rsp_ch.found_key,
                 rsp_ch.found_slot, rsp_ch.entry_count};
         if (answer_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response word %p", got);
         end else begin
            want = answer_queue.pop_front();
            typed = typed_valid.pop_front();
            typed_ans = typed_answers.pop_front();
            if (typed && typed_ans != want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("table row disagrees: table %p predicted %p", typed_ans, want);
            end
            if (got != want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   task automatic send_word(input op_word_type op, input logic has_ans,
                            input answer_type ans);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.action <= op.action;
      req_ch.node_id <= op.node_id;
      req_ch.node_x <= op.node_x;
      req_ch.node_y <= op.node_y;
      req_ch.path_length <= op.path_length;
      req_ch.slot <= op.slot;
      do @(posedge clock); while (!req_ch.ready);
      answer_queue.push_back(queue_step(op));
      typed_valid.push_back(has_ans);
      typed_answers.push_back(ans);
   endtask

   task automatic drain_queue();
      req_ch.valid <= 1'b0;
      while (answer_queue.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_GOAL_X:      m_goal_x = v;
         CSR_GOAL_Y:      m_goal_y = v;
         CSR_PATH_WEIGHT: m_path_w = v[WEIGHT_W-1:0];
         default:         m_goal_w = v[WEIGHT_W-1:0];
      endcase
   endtask

   function automatic logic [ACTION_W-1:0] pick_action(input int r);
      return ACTION_W'(1 + (r % 6));
   endfunction

   function automatic op_word_type random_word(input int id_span);
      op_word_type op;
      int r;
      op.node_id = NODE_W'($urandom_range(id_span));
      op.node_x = COORD_W'($urandom);
      op.node_y = COORD_W'($urandom);
      if ($urandom_range(9) == 0) begin
         op.node_x = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         op.node_y = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      end
      r = $urandom_range(19);
      op.path_length = r == 0 ? PATH_INF : (r < 4 ? PLEN_W'($urandom) :
                       PLEN_W'($urandom_range(4095)));
      op.slot = SLOT_W'(m_fill > 0 && $urandom_range(3) != 0 ?
                $urandom_range(m_fill - 1) : $urandom);
      r = $urandom_range(99);
      if (r < 45) op.action = ACT_INSERT;
      else if (r < 97) op.action = pick_action(r);
      else op.action = ACT_UNUSED;
      return op;
   endfunction

   table_row_type directed_rows[$];

   initial begin
      op_word_type op;
      answer_type none;
      int phase;
      none = '0;
      req_ch.valid <= 1'b0;
      req_ch.action <= '0;
      req_ch.node_id <= '0;
      req_ch.node_x <= '0;
      req_ch.node_y <= '0;
      req_ch.path_length <= '0;
      req_ch.slot <= '0;
      m_goal_x = 0; m_goal_y = 0; m_path_w = WEIGHT_RESET; m_goal_w = WEIGHT_RESET;
      m_fill = 0;
      for (int i = 0; i < DEPTH; i++) begin m_ids[i] = 0; m_keys[i] = 0; end

      //                action          id    x         y         plen        slot
      directed_rows = '{
         '{'{ACT_POP,        8'd0,  16'sd0,   16'sd0,   24'd0,     5'd0}, 1'b1,
           '{ST_EMPTY, 8'd0, 32'd0, 5'd0, 6'd0}},
         '{'{ACT_PEEK,       8'd0,  16'sd0,   16'sd0,   24'd0,     5'd0}, 1'b1,
           '{ST_EMPTY, 8'd0, 32'd0, 5'd0, 6'd0}},
         '{'{ACT_READ,       8'd0,  16'sd0,   16'sd0,   24'd0,     5'd0}, 1'b1,
           '{ST_EMPTY, 8'd0, 32'd0, 5'd0, 6'd0}},
         '{'{ACT_FIND,       8'd9,  16'sd0,   16'sd0,   24'd0,     5'd0}, 1'b1,
           '{ST_NOT_FOUND, 8'd0, 32'd0, 5'd0, 6'd0}},
         '{'{ACT_REMOVE_ID,  8'd9,  16'sd0,   16'sd0,   24'd0,     5'd0}, 1'b1,
           '{ST_NOT_FOUND, 8'd0, 32'd0, 5'd0, 6'd0}},
         '{'{ACT_UNUSED,     8'd0,  16'sd0,   16'sd0,   24'd0,     5'd0}, 1'b1,
           '{ST_EMPTY, 8'd0, 32'd0, 5'd0, 6'd0}},
         '{'{ACT_INSERT,     8'd1,  16'sd0,   16'sd0,   PATH_INF,  5'd0}, 1'b1,
           '{ST_OK, 8'd1, KEY_INF, 5'd0, 6'd1}},
         '{'{ACT_INSERT,     8'd2,  16'sd0,   16'sd0,   24'd0,     5'd0}, 1'b1,
           '{ST_OK, 8'd2, 32'd0, 5'd1, 6'd2}},
         '{'{ACT_INSERT,     8'd3,  16'sd0,   16'sd0,   24'd0,     5'd0}, 1'b1,
           '{ST_OK, 8'd3, 32'd0, 5'd2, 6'd3}},
         '{'{ACT_INSERT,     8'd255,16'sh7FFF,16'sh8000,24'hFF_FFFE,5'd31}, 1'b0, none},
         '{'{ACT_INSERT,     8'd255,16'sd3,   16'sd4,   24'hFF_FFFE,5'd0}, 1'b0, none},
         '{'{ACT_INSERT,     8'd2,  16'sd0,   16'sd0,   24'd100,   5'd0}, 1'b0, none},
         '{'{ACT_INSERT,     8'd3,  16'sd30,  16'sd40,  24'd0,     5'd0}, 1'b0, none},
         '{'{ACT_INSERT,     8'd4,  16'sd30,  16'sd40,  24'd0,     5'd0}, 1'b0, none},
         '{'{ACT_FIND,       8'd4,  16'sd0,   16'sd0,   24'd0,     5'd0}, 1'b0, none},
         '{'{ACT_READ,       8'd0,  16'sd0,   16'sd0,   24'd0,     5'd31}, 1'b0, none},
         '{'{ACT_READ,       8'd0,  16'sd0,   16'sd0,   24'd0,     5'd1}, 1'b0, none},
         '{'{ACT_REMOVE_IDX, 8'd0,  16'sd0,   16'sd0,   24'd0,     5'd1}, 1'b0, none},
         '{'{ACT_REMOVE_ID,  8'd3,  16'sd0,   16'sd0,   24'd0,     5'd0}, 1'b0, none},
         '{'{ACT_PEEK,       8'd0,  16'sd0,   16'sd0,   24'd0,     5'd0}, 1'b0, none},
         '{'{ACT_POP,        8'd0,  16'sd0,   16'sd0,   24'd0,     5'd0}, 1'b0, none},
         '{'{ACT_POP,        8'd0,  16'sd0,   16'sd0,   24'd0,     5'd0}, 1'b0, none}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_word(directed_rows[i].op, directed_rows[i].has_answer,
                   directed_rows[i].answer);
      drain_queue();

      // fill to capacity, then overflow
      for (int i = 0; i < DEPTH + 2; i++) begin
         op = '0;
         op.action = ACT_INSERT;
         op.node_id = NODE_W'(100 + i);
         op.path_length = PLEN_W'($urandom_range(255));
         send_word(op, 1'b0, none);
      end
      drain_queue();
      write_reg(CSR_PATH_WEIGHT, 16'hFFFF);
      write_reg(CSR_GOAL_WEIGHT, 16'h0FFF);
      write_reg(CSR_GOAL_X, 16'h8000);
      write_reg(CSR_GOAL_Y, 16'h7FFF);

      for (phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
            default: begin send_idle_pct = 20; recv_stall_pct = 20; end
         endcase
         if (phase == 4) hold_off_cycles = 600;
         for (int k = 0; k < 100; k++)
            send_word(random_word(phase < 4 ? 47 : 255), 1'b0, none);
         drain_queue();
         case (phase)
            0: begin
               write_reg(CSR_PATH_WEIGHT, 16'h0000);
               write_reg(CSR_GOAL_WEIGHT, 16'h0000);
            end
            1: begin
               write_reg(CSR_GOAL_X, 16'h7FFF);
               write_reg(CSR_GOAL_Y, 16'h8000);
            end
            2: begin
               write_reg(CSR_PATH_WEIGHT, 16'h0100);
               write_reg(CSR_GOAL_WEIGHT, 16'h0FFF);
            end
            default: begin
               write_reg(CSR_GOAL_X, 16'($urandom));
               write_reg(CSR_GOAL_Y, 16'($urandom));
               write_reg(CSR_PATH_WEIGHT, 16'($urandom));
               write_reg(CSR_GOAL_WEIGHT, 16'($urandom));
            end
         endcase
      end

      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
